FILE: design/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and operation codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  // operation codes carried in the kind field
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_APPEND = 2'd3;

  // request beat
  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [7:0]  position;
    logic signed [31:0] item_value;
  } ils_in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] read_value;
    logic               read_valid;
    logic               applied;
    logic        [6:0]  length_now;
  } ils_out_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDWAIT = 6'b000010,
    S_INS    = 6'b000100,
    S_DEL    = 6'b001000,
    S_PUT    = 6'b010000,
    S_DONE   = 6'b100000
  } ils_state_e;

endpackage

FILE: design/indexed_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to CAPACITY signed 32-bit values with read, insert,
// delete and append by position, held in a single-port-write memory.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake               beat
//   in       in   in_valid_i / in_stall_o   ils_in_t  (kind, position, item_value)
//   out      out  out_valid_o / out_stall_i ils_out_t (read_value, read_valid,
//                                                      applied, length_now)
//
// one request at a time: read waits for the registered read data; append,
// refused requests, insert at the tail and removal of the last entry finish
// from idle; insert and delete at p shift the entries behind p, one entry
// moved per cycle through the memory's read-then-write path.
// reset clears the length and the control state; entry storage is not cleared
// the result sits in an output register, so the next request is taken while
// a finished beat is still stalled on the out side
// ----------------------------------------------------------------------------
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ils_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ils_out_t out_data_o
);

  // address bits for the entries, length bits able to hold CAPACITY itself
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic          res_valid;
  logic          res_ready;
  ils_out_t      res;

  logic          out_valid_q;
  ils_out_t      out_q;

  // entry memory, registered read data
  ils_mem #(
    .Depth (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // decode and shift sequencer
  ils_seq #(
    .Capacity (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  // output register takes a new beat when empty or when its beat leaves
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/ils_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ils_mem #(
  parameter int Depth = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ils_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_seq
// Operation sequencer: decodes a request, walks the entry memory to shift
// values for insert and delete, and holds the result until it is handed off.
// ----------------------------------------------------------------------------
module ils_seq
  import ils_pkg::*;
#(
  parameter int Capacity = 64,
  parameter int AW       = 6,
  parameter int LW       = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ils_in_t       in_data_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output ils_out_t      res_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [31:0]   wdata_o,
  output logic [AW-1:0] raddr_o,
  input  logic [31:0]   rdata_i
);

  localparam int CW = ((LW > 7) ? LW : 7) + 1;

  ils_state_e    state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] p_q, p_d;
  logic [AW-1:0] wr_q, wr_d;
  logic [31:0]   val_q, val_d;
  ils_out_t      res_q, res_d;

  logic [6:0]    pos7;
  logic          pos_neg;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] ins_ext;
  logic [CW-1:0] len_ext;
  logic          pos_in;
  logic          not_full;

  assign pos7     = in_data_i.position[6:0];
  assign pos_neg  = in_data_i.position[7];
  assign pos_ext  = CW'(pos7);
  assign ins_ext  = pos_neg ? '0 : pos_ext;
  assign len_ext  = CW'(len_q);
  assign pos_in   = !pos_neg && (pos_ext < len_ext);
  assign not_full = (len_ext < CW'(Capacity));

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    p_d     = p_q;
    wr_d    = wr_q;
    val_d   = val_q;
    res_d   = res_q;
    we_o    = 1'b0;
    waddr_o = wr_q;
    wdata_o = rdata_i;
    raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d            = in_data_i.item_value;
          res_d            = '0;
          res_d.length_now = 7'(len_q);
          state_d          = S_DONE;
          case (in_data_i.kind)
            KIND_READ: begin
              if (pos_in) begin
                raddr_o = AW'(pos7);
                state_d = S_RDWAIT;
              end
            end
            KIND_INSERT: begin
              if (not_full && (ins_ext <= len_ext)) begin
                p_d = AW'(ins_ext);
                if (ins_ext == len_ext) begin
                  // insert at the tail needs no shift
                  we_o             = 1'b1;
                  waddr_o          = AW'(ins_ext);
                  wdata_o          = in_data_i.item_value;
                  len_d            = len_q + 1'b1;
                  res_d.applied    = 1'b1;
                  res_d.length_now = 7'(len_q + 1'b1);
                end else begin
                  raddr_o = AW'(len_q - 1'b1);
                  wr_d    = AW'(len_q);
                  state_d = S_INS;
                end
              end
            end
            KIND_DELETE: begin
              if (pos_in) begin
                if ((pos_ext + 1'b1) == len_ext) begin
                  // last entry: only the length shrinks
                  len_d            = len_q - 1'b1;
                  res_d.applied    = 1'b1;
                  res_d.length_now = 7'(len_q - 1'b1);
                end else begin
                  raddr_o = AW'(pos7) + 1'b1;
                  wr_d    = AW'(pos7);
                  state_d = S_DEL;
                end
              end
            end
            KIND_APPEND: begin
              if (not_full) begin
                we_o             = 1'b1;
                waddr_o          = AW'(len_q);
                wdata_o          = in_data_i.item_value;
                len_d            = len_q + 1'b1;
                res_d.applied    = 1'b1;
                res_d.length_now = 7'(len_q + 1'b1);
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RDWAIT: begin
        res_d.read_value = rdata_i;
        res_d.read_valid = 1'b1;
        state_d          = S_DONE;
      end
      S_INS: begin
        // move entry wr-1 up to wr, walking toward the head
        we_o    = 1'b1;
        waddr_o = wr_q;
        wdata_o = rdata_i;
        if (AW'(wr_q - 1'b1) != p_q) begin
          raddr_o = AW'(wr_q - 2'd2);
          wr_d    = wr_q - 1'b1;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        we_o             = 1'b1;
        waddr_o          = p_q;
        wdata_o          = val_q;
        len_d            = len_q + 1'b1;
        res_d.applied    = 1'b1;
        res_d.length_now = 7'(len_q + 1'b1);
        state_d          = S_DONE;
      end
      S_DEL: begin
        // move entry wr+1 down to wr, walking toward the tail
        we_o    = 1'b1;
        waddr_o = wr_q;
        wdata_o = rdata_i;
        if ((CW'(wr_q) + CW'(2)) < len_ext) begin
          raddr_o = AW'(wr_q + 2'd2);
          wr_d    = wr_q + 1'b1;
        end else begin
          len_d            = len_q - 1'b1;
          res_d.applied    = 1'b1;
          res_d.length_now = 7'(len_q - 1'b1);
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    wr_q  <= wr_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
